### design/pll_pkg.sv
// Shared types and codes for the positional linked list engine.
package pll_pkg;

    // Fixed field widths
    localparam int MODE_W  = 3;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 7;

    // Operation codes carried in the mode field
    localparam logic [MODE_W-1:0] MODE_INS_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_INS_AT    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_INS_BACK  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DEL_FRONT = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DEL_AT    = 3'd4;
    localparam logic [MODE_W-1:0] MODE_DEL_BACK  = 3'd5;
    localparam logic [MODE_W-1:0] MODE_READ      = 3'd6;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_INVALID = 2'd1,
        STATUS_EMPTY   = 2'd2,
        STATUS_FULL    = 2'd3
    } status_t;

    typedef struct packed {
        logic [MODE_W-1:0]         mode;
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          position;
    } req_t;

    typedef struct packed {
        status_t                   status;
        logic signed [VALUE_W-1:0] item_value;
        logic                      last_item;
    } rsp_t;

    // Node memory controls from the sequencer
    typedef struct packed {
        logic rd_en;
        logic val_we;
        logic link_we;
    } mem_ctrl_t;

    // Slot map requests from the sequencer
    typedef struct packed {
        logic grab;
        logic drop;
    } slot_req_t;

endpackage

### design/pll_mem.sv
// Node value and link memories with one shared registered read port.
module pll_mem #(
    parameter int CAPACITY = 64
) (
    input  logic                                  clk,
    input  pll_pkg::mem_ctrl_t                    ctrl,
    input  logic [$clog2(CAPACITY)-1:0]           rd_addr,
    input  logic [$clog2(CAPACITY)-1:0]           val_waddr,
    input  logic signed [pll_pkg::VALUE_W-1:0]    val_wdata,
    input  logic [$clog2(CAPACITY)-1:0]           link_waddr,
    input  logic [$clog2(CAPACITY)-1:0]           link_wdata,
    output logic signed [pll_pkg::VALUE_W-1:0]    val_rdata,
    output logic [$clog2(CAPACITY)-1:0]           link_rdata
);
    localparam int SLOT_W = $clog2(CAPACITY);

    logic signed [pll_pkg::VALUE_W-1:0] val_mem [CAPACITY];
    logic [SLOT_W-1:0]                  link_mem [CAPACITY];

    // Value store
    always_ff @(posedge clk)
    begin
        if (ctrl.val_we)
        begin
            val_mem[val_waddr] <= val_wdata;
        end
        if (ctrl.rd_en)
        begin
            val_rdata <= val_mem[rd_addr];
        end
    end

    // Link store
    always_ff @(posedge clk)
    begin
        if (ctrl.link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        if (ctrl.rd_en)
        begin
            link_rdata <= link_mem[rd_addr];
        end
    end

endmodule

### design/pll_slots.sv
// Occupied-slot map with lowest-free-slot allocation.
module pll_slots #(
    parameter int CAPACITY = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  pll_pkg::slot_req_t          req,
    input  logic [$clog2(CAPACITY)-1:0] drop_slot,
    output logic [$clog2(CAPACITY)-1:0] free_slot
);
    localparam int SLOT_W = $clog2(CAPACITY);

    logic [CAPACITY-1:0] used_reg;
    logic [CAPACITY-1:0] used_next;

    // Lowest clear bit wins
    always_comb
    begin
        free_slot = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_slot = SLOT_W'(i);
            end
        end
    end

    always_comb
    begin
        used_next = used_reg;
        if (req.grab)
        begin
            used_next[free_slot] = 1'b1;
        end
        if (req.drop)
        begin
            used_next[drop_slot] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else
        begin
            used_reg <= used_next;
        end
    end

endmodule

### design/positional_linked_list_engine.sv
// Linked list engine: sequencer that walks node links one read per cycle.
// Throughput: one item at a time; a new item is taken only in the idle state, so
// service is set by the link walk through the single memory read port.
// Read-out: the next element's read is issued as each element is emitted.
// Reset clears the slot map, head and count; node memories are not cleared.
module positional_linked_list_engine #(
    parameter int CAPACITY = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  pll_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output pll_pkg::rsp_t rsp
);
    localparam int SLOT_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int PW     = pll_pkg::POS_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WALK,
        S_LINK,
        S_INS_FIX,
        S_DEL_FIX,
        S_DEL_HEAD,
        S_FINISH,
        S_RD_ISSUE,
        S_RD_EMIT
    } state_t;

    state_t            state_reg, state_next;
    logic [SLOT_W-1:0] cur_reg, cur_next;
    logic [CNT_W-1:0]  left_reg, left_next;
    logic              from_mem_reg, from_mem_next;
    logic [SLOT_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [SLOT_W-1:0] fresh_reg, fresh_next;
    logic [SLOT_W-1:0] victim_reg, victim_next;
    logic              is_ins_reg, is_ins_next;
    pll_pkg::status_t  status_reg, status_next;
    logic              rsp_valid_reg, rsp_valid_next;
    pll_pkg::rsp_t     rsp_reg, rsp_next;

    pll_pkg::mem_ctrl_t                 mem_ctrl;
    logic [SLOT_W-1:0]                  rd_addr;
    logic [SLOT_W-1:0]                  val_waddr;
    logic [SLOT_W-1:0]                  link_waddr;
    logic [SLOT_W-1:0]                  link_wdata;
    logic signed [pll_pkg::VALUE_W-1:0] val_rdata;
    logic [SLOT_W-1:0]                  link_rdata;

    pll_pkg::slot_req_t slot_req;
    logic [SLOT_W-1:0]  drop_slot;
    logic [SLOT_W-1:0]  free_slot;

    logic              can_load;
    logic              is_insert;
    logic              is_delete;
    logic [PW-1:0]     count_ext;
    logic [PW-1:0]     ins_pos;
    logic [PW-1:0]     del_pos;
    logic [SLOT_W-1:0] walk_cur;

    pll_mem #(.CAPACITY(CAPACITY)) u_mem (
        .clk        (clk),
        .ctrl       (mem_ctrl),
        .rd_addr    (rd_addr),
        .val_waddr  (val_waddr),
        .val_wdata  (req.value),
        .link_waddr (link_waddr),
        .link_wdata (link_wdata),
        .val_rdata  (val_rdata),
        .link_rdata (link_rdata)
    );

    pll_slots #(.CAPACITY(CAPACITY)) u_slots (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (slot_req),
        .drop_slot (drop_slot),
        .free_slot (free_slot)
    );

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign can_load  = !rsp_valid_reg || !rsp_stall;

    // Decode of the incoming item
    assign is_insert = (req.mode == pll_pkg::MODE_INS_FRONT) ||
                       (req.mode == pll_pkg::MODE_INS_AT) ||
                       (req.mode == pll_pkg::MODE_INS_BACK);
    assign is_delete = (req.mode == pll_pkg::MODE_DEL_FRONT) ||
                       (req.mode == pll_pkg::MODE_DEL_AT) ||
                       (req.mode == pll_pkg::MODE_DEL_BACK);
    assign count_ext = PW'(count_reg);

    always_comb
    begin
        priority case (req.mode)
            pll_pkg::MODE_INS_FRONT: ins_pos = '0;
            pll_pkg::MODE_INS_BACK:  ins_pos = count_ext;
            default:                 ins_pos = req.position;
        endcase
        priority case (req.mode)
            pll_pkg::MODE_DEL_FRONT: del_pos = '0;
            pll_pkg::MODE_DEL_BACK:  del_pos = PW'(count_reg - CNT_W'(1));
            default:                 del_pos = req.position;
        endcase
    end

    // Current slot of a walk: first step from the register, then from memory
    assign walk_cur = from_mem_reg ? link_rdata : cur_reg;

    // Sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        left_next      = left_reg;
        from_mem_next  = from_mem_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        fresh_next     = fresh_reg;
        victim_next    = victim_reg;
        is_ins_next    = is_ins_reg;
        status_next    = status_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        mem_ctrl       = '0;
        rd_addr        = cur_reg;
        val_waddr      = free_slot;
        link_waddr     = cur_reg;
        link_wdata     = fresh_reg;
        slot_req       = '0;
        drop_slot      = victim_reg;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    status_next = pll_pkg::STATUS_OK;
                    state_next  = S_FINISH;
                    if (req.mode == pll_pkg::MODE_READ)
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = pll_pkg::STATUS_EMPTY;
                        end
                        else
                        begin
                            cur_next   = head_reg;
                            left_next  = count_reg;
                            state_next = S_RD_ISSUE;
                        end
                    end
                    else if (is_insert)
                    begin
                        if (count_reg == CNT_W'(CAPACITY))
                        begin
                            status_next = pll_pkg::STATUS_FULL;
                        end
                        else if (ins_pos > count_ext)
                        begin
                            status_next = pll_pkg::STATUS_INVALID;
                        end
                        else
                        begin
                            // claim a slot and store the value now
                            slot_req.grab   = 1'b1;
                            mem_ctrl.val_we = 1'b1;
                            fresh_next      = free_slot;
                            is_ins_next     = 1'b1;
                            if (ins_pos == '0)
                            begin
                                mem_ctrl.link_we = 1'b1;
                                link_waddr       = free_slot;
                                link_wdata       = head_reg;
                                head_next        = free_slot;
                                count_next       = count_reg + CNT_W'(1);
                            end
                            else
                            begin
                                cur_next      = head_reg;
                                left_next     = CNT_W'(ins_pos - PW'(1));
                                from_mem_next = 1'b0;
                                state_next    = S_WALK;
                            end
                        end
                    end
                    else if (is_delete)
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = pll_pkg::STATUS_EMPTY;
                        end
                        else if (del_pos >= count_ext)
                        begin
                            status_next = pll_pkg::STATUS_INVALID;
                        end
                        else
                        begin
                            is_ins_next = 1'b0;
                            if (del_pos == '0)
                            begin
                                mem_ctrl.rd_en = 1'b1;
                                rd_addr        = head_reg;
                                state_next     = S_DEL_HEAD;
                            end
                            else
                            begin
                                cur_next      = head_reg;
                                left_next     = CNT_W'(del_pos - PW'(1));
                                from_mem_next = 1'b0;
                                state_next    = S_WALK;
                            end
                        end
                    end
                end
            end

            // one link followed per cycle until the predecessor is reached
            S_WALK:
            begin
                mem_ctrl.rd_en = 1'b1;
                rd_addr        = walk_cur;
                if (left_reg == '0)
                begin
                    cur_next   = walk_cur;
                    state_next = S_LINK;
                end
                else
                begin
                    left_next     = left_reg - CNT_W'(1);
                    from_mem_next = 1'b1;
                end
            end

            // link_rdata holds the predecessor's successor
            S_LINK:
            begin
                if (is_ins_reg)
                begin
                    mem_ctrl.link_we = 1'b1;
                    link_waddr       = fresh_reg;
                    link_wdata       = link_rdata;
                    state_next       = S_INS_FIX;
                end
                else
                begin
                    victim_next    = link_rdata;
                    mem_ctrl.rd_en = 1'b1;
                    rd_addr        = link_rdata;
                    state_next     = S_DEL_FIX;
                end
            end

            S_INS_FIX:
            begin
                mem_ctrl.link_we = 1'b1;
                link_waddr       = cur_reg;
                link_wdata       = fresh_reg;
                count_next       = count_reg + CNT_W'(1);
                state_next       = S_FINISH;
            end

            // bypass the victim
            S_DEL_FIX:
            begin
                mem_ctrl.link_we = 1'b1;
                link_waddr       = cur_reg;
                link_wdata       = link_rdata;
                slot_req.drop    = 1'b1;
                drop_slot        = victim_reg;
                count_next       = count_reg - CNT_W'(1);
                state_next       = S_FINISH;
            end

            S_DEL_HEAD:
            begin
                head_next     = link_rdata;
                slot_req.drop = 1'b1;
                drop_slot     = head_reg;
                count_next    = count_reg - CNT_W'(1);
                state_next    = S_FINISH;
            end

            S_FINISH:
            begin
                if (can_load)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next.status      = status_reg;
                    rsp_next.item_value  = '0;
                    rsp_next.last_item   = 1'b1;
                    state_next           = S_IDLE;
                end
            end

            S_RD_ISSUE:
            begin
                mem_ctrl.rd_en = 1'b1;
                rd_addr        = cur_reg;
                state_next     = S_RD_EMIT;
            end

            // emit one element; read data holds while the result side stalls
            S_RD_EMIT:
            begin
                if (can_load)
                begin
                    rsp_valid_next      = 1'b1;
                    rsp_next.status     = pll_pkg::STATUS_OK;
                    rsp_next.item_value = val_rdata;
                    rsp_next.last_item  = (left_reg == CNT_W'(1));
                    left_next           = left_reg - CNT_W'(1);
                    if (left_reg == CNT_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        mem_ctrl.rd_en = 1'b1;
                        rd_addr        = link_rdata;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cur_reg       <= '0;
            left_reg      <= '0;
            from_mem_reg  <= 1'b0;
            head_reg      <= '0;
            count_reg     <= '0;
            fresh_reg     <= '0;
            victim_reg    <= '0;
            is_ins_reg    <= 1'b0;
            status_reg    <= pll_pkg::STATUS_OK;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            left_reg      <= left_next;
            from_mem_reg  <= from_mem_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            fresh_reg     <= fresh_next;
            victim_reg    <= victim_next;
            is_ins_reg    <= is_ins_next;
            status_reg    <= status_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("element count above capacity");

    a_value_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.status == pll_pkg::STATUS_OK || rsp.item_value == '0))
        else $error("element value on a non-ok result");

    a_walk_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK && left_reg != '0) |=> left_reg == $past(left_reg) - CNT_W'(1))
        else $error("walk counter did not step");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("accepted a new item before finishing the last one");
`endif

endmodule

### tb/sv/positional_linked_list_engine_test.sv
// Self-checking testbench for the positional linked list engine.
`timescale 1ns / 1ps

module positional_linked_list_engine_test;

    localparam int CAPACITY = 64;
    // Mode 7 has no operation; the block answers it with a plain ok
    localparam logic [pll_pkg::MODE_W-1:0] MODE_SPARE = 3'd7;
    // Receiver hold-off that backs the block up into its request side
    localparam int unsigned BACKLOG_CYCLES = 400;
    localparam int unsigned BACKLOG_AT = 120;
    localparam int unsigned RANDOM_ITEMS = 285;
    // Drain margin covers the worst link walk over a full list
    localparam int unsigned DRAIN_CYCLES = CAPACITY + 16;
    // Longest quiet stretch in a correct run: backlog hold plus one long
    // stall or gap plus a full walk; taken several times over
    localparam int unsigned WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        pll_pkg::req_t    item;
        logic             fixed;
        pll_pkg::status_t fixed_status;
    } plan_row_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          req_valid = 1'b0;
    logic          req_stall;
    pll_pkg::req_t req = '0;
    logic          rsp_valid;
    logic          rsp_stall = 1'b0;
    pll_pkg::rsp_t rsp;

    // Predicted list state
    logic signed [pll_pkg::VALUE_W-1:0] node_val [CAPACITY];
    logic [5:0]                         node_next [CAPACITY];
    logic [CAPACITY-1:0]                slot_busy;
    logic [5:0]                         list_head;
    int unsigned                        list_count;

    pll_pkg::rsp_t awaited_rsp [$];
    plan_row_t     directed_plan [$];
    int unsigned   error_count = 0;
    int unsigned   sender_quiet = 0;
    int unsigned   receiver_quiet = 0;
    bit            backlog_req = 1'b0;
    bit            growing = 1'b1;
    int unsigned   edge_hits = 0;

    positional_linked_list_engine #(
        .CAPACITY(CAPACITY)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp(rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Slot reached after the given number of hops from the head
    function automatic logic [5:0] walk_links(input int unsigned steps);
        logic [5:0] s;
        s = list_head;
        for (int i = 0; i < steps; i++)
            s = node_next[s];
        return s;
    endfunction

    function automatic pll_pkg::status_t list_insert(
        input int unsigned pos,
        input logic signed [pll_pkg::VALUE_W-1:0] val);
        logic [5:0] fresh;
        logic [5:0] prev;
        if (list_count >= CAPACITY)
            return pll_pkg::STATUS_FULL;
        if (pos > list_count)
            return pll_pkg::STATUS_INVALID;
        // lowest free slot
        fresh = '0;
        for (int s = CAPACITY - 1; s >= 0; s--)
            if (!slot_busy[s])
                fresh = 6'(s);
        slot_busy[fresh] = 1'b1;
        node_val[fresh] = val;
        if (pos == 0)
        begin
            node_next[fresh] = list_head;
            list_head = fresh;
        end
        else
        begin
            prev = walk_links(pos - 1);
            node_next[fresh] = node_next[prev];
            node_next[prev] = fresh;
        end
        list_count++;
        return pll_pkg::STATUS_OK;
    endfunction

    function automatic pll_pkg::status_t list_remove(input int unsigned pos);
        logic [5:0] victim;
        logic [5:0] prev;
        if (list_count == 0)
            return pll_pkg::STATUS_EMPTY;
        if (pos >= list_count)
            return pll_pkg::STATUS_INVALID;
        if (pos == 0)
        begin
            victim = list_head;
            list_head = node_next[victim];
        end
        else
        begin
            prev = walk_links(pos - 1);
            victim = node_next[prev];
            node_next[prev] = node_next[victim];
        end
        slot_busy[victim] = 1'b0;
        list_count--;
        return pll_pkg::STATUS_OK;
    endfunction

    // Apply one accepted item to the predicted list and queue its results
    function automatic void predict_list_op(input pll_pkg::req_t item);
        pll_pkg::rsp_t r;
        logic [5:0]    s;
        r.status = pll_pkg::STATUS_OK;
        r.item_value = '0;
        r.last_item = 1'b1;
        if (item.mode == pll_pkg::MODE_READ && list_count != 0)
        begin
            s = list_head;
            for (int k = 0; k < list_count; k++)
            begin
                r.item_value = node_val[s];
                r.last_item = (k + 1 == list_count);
                awaited_rsp.push_back(r);
                s = node_next[s];
            end
            return;
        end
        unique case (item.mode)
            pll_pkg::MODE_INS_FRONT: r.status = list_insert(0, item.value);
            pll_pkg::MODE_INS_AT:    r.status = list_insert(item.position, item.value);
            pll_pkg::MODE_INS_BACK:  r.status = list_insert(list_count, item.value);
            pll_pkg::MODE_DEL_FRONT: r.status = list_remove(0);
            pll_pkg::MODE_DEL_AT:    r.status = list_remove(item.position);
            pll_pkg::MODE_DEL_BACK:  r.status = (list_count == 0) ? pll_pkg::STATUS_EMPTY
                                                : list_remove(list_count - 1);
            pll_pkg::MODE_READ:      r.status = pll_pkg::STATUS_EMPTY;
            default:                 r.status = pll_pkg::STATUS_OK;
        endcase
        awaited_rsp.push_back(r);
    endfunction

    // Mostly no gap, some short ones, a few long, and now and then a quiet run
    function automatic int unsigned pick_gap(inout int unsigned quiet);
        int unsigned r;
        if (quiet > 0)
        begin
            quiet--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            quiet = $urandom_range(10, 40);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [pll_pkg::VALUE_W-1:0] random_value();
        unique case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // Random item; the list drifts between empty and full so both edges are hit
    function automatic pll_pkg::req_t random_item();
        pll_pkg::req_t it;
        int unsigned   r;
        if (growing && list_count == CAPACITY && ++edge_hits > 4)
        begin
            growing = 1'b0;
            edge_hits = 0;
        end
        else if (!growing && list_count == 0 && ++edge_hits > 4)
        begin
            growing = 1'b1;
            edge_hits = 0;
        end
        r = $urandom_range(0, 99);
        if (!growing)
            r = (r < 88) ? 87 - r : r;
        // growing: inserts heavy; shrinking: the same table mirrored to deletes
        if (r < 25)
            it.mode = growing ? pll_pkg::MODE_INS_FRONT : pll_pkg::MODE_DEL_FRONT;
        else if (r < 50)
            it.mode = growing ? pll_pkg::MODE_INS_AT : pll_pkg::MODE_DEL_AT;
        else if (r < 75)
            it.mode = growing ? pll_pkg::MODE_INS_BACK : pll_pkg::MODE_DEL_BACK;
        else if (r < 80)
            it.mode = growing ? pll_pkg::MODE_DEL_FRONT : pll_pkg::MODE_INS_FRONT;
        else if (r < 85)
            it.mode = growing ? pll_pkg::MODE_DEL_AT : pll_pkg::MODE_INS_AT;
        else if (r < 88)
            it.mode = growing ? pll_pkg::MODE_DEL_BACK : pll_pkg::MODE_INS_BACK;
        else if (r < 97)
            it.mode = pll_pkg::MODE_READ;
        else
            it.mode = MODE_SPARE;
        it.value = random_value();
        it.position = pll_pkg::POS_W'($urandom_range(0, 127));
        if ($urandom_range(0, 9) != 0)
        begin
            if (it.mode == pll_pkg::MODE_INS_AT)
                it.position = pll_pkg::POS_W'($urandom_range(0, list_count));
            else if (it.mode == pll_pkg::MODE_DEL_AT && list_count != 0)
                it.position = pll_pkg::POS_W'($urandom_range(0, list_count - 1));
        end
        return it;
    endfunction

    task automatic add_row(input logic [pll_pkg::MODE_W-1:0] m,
                           input logic [pll_pkg::VALUE_W-1:0] v,
                           input logic [pll_pkg::POS_W-1:0] p, input logic fixed,
                           input pll_pkg::status_t st);
        plan_row_t row;
        row.item.mode = m;
        row.item.value = v;
        row.item.position = p;
        row.fixed = fixed;
        row.fixed_status = st;
        directed_plan.push_back(row);
    endtask

    // Offer one item, hold it until taken, then record what it should produce
    task automatic offer_item(input pll_pkg::req_t item, input logic fixed,
                              input pll_pkg::status_t st);
        int unsigned   gap;
        int unsigned   n;
        pll_pkg::rsp_t r;
        req_valid <= 1'b1;
        req <= item;
        @(posedge clk);
        while (req_stall !== 1'b0)
            @(posedge clk);
        n = awaited_rsp.size();
        predict_list_op(item);
        if (fixed)
        begin
            // error and after-reset rows carry a hand-written result
            while (awaited_rsp.size() > n)
                void'(awaited_rsp.pop_back());
            r.status = st;
            r.item_value = '0;
            r.last_item = 1'b1;
            awaited_rsp.push_back(r);
        end
        gap = pick_gap(sender_quiet);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Request side: reset, directed table, random items, then drain
    initial
    begin : req_side
        pll_pkg::req_t item;
        slot_busy = '0;
        list_head = '0;
        list_count = 0;

        add_row(pll_pkg::MODE_DEL_FRONT, 32'h0, 7'd0, 1'b1, pll_pkg::STATUS_EMPTY);
        add_row(pll_pkg::MODE_DEL_AT, 32'h0, 7'd0, 1'b1, pll_pkg::STATUS_EMPTY);
        add_row(pll_pkg::MODE_DEL_BACK, 32'h0, 7'd0, 1'b1, pll_pkg::STATUS_EMPTY);
        add_row(pll_pkg::MODE_READ, 32'h0, 7'd0, 1'b1, pll_pkg::STATUS_EMPTY);
        add_row(pll_pkg::MODE_INS_AT, 32'h1, 7'd1, 1'b1, pll_pkg::STATUS_INVALID);
        add_row(MODE_SPARE, 32'hFFFF_FFFF, 7'd127, 1'b1, pll_pkg::STATUS_OK);
        // positional insert at zero on an empty list goes to the front
        add_row(pll_pkg::MODE_INS_AT, 32'h7FFF_FFFF, 7'd0, 1'b1, pll_pkg::STATUS_OK);
        add_row(pll_pkg::MODE_INS_FRONT, 32'h8000_0000, 7'd0, 1'b1, pll_pkg::STATUS_OK);
        add_row(pll_pkg::MODE_INS_BACK, 32'hFFFF_FFFF, 7'd0, 1'b1, pll_pkg::STATUS_OK);
        add_row(pll_pkg::MODE_INS_AT, 32'h0, 7'd3, 1'b0, pll_pkg::STATUS_OK);
        add_row(pll_pkg::MODE_INS_AT, 32'h1234_5678, 7'd2, 1'b0, pll_pkg::STATUS_OK);
        add_row(pll_pkg::MODE_READ, 32'h0, 7'd0, 1'b0, pll_pkg::STATUS_OK);
        add_row(pll_pkg::MODE_INS_AT, 32'h5, 7'd127, 1'b1, pll_pkg::STATUS_INVALID);
        add_row(pll_pkg::MODE_DEL_AT, 32'h0, 7'd127, 1'b1, pll_pkg::STATUS_INVALID);
        add_row(pll_pkg::MODE_DEL_AT, 32'h0, 7'd5, 1'b1, pll_pkg::STATUS_INVALID);
        add_row(pll_pkg::MODE_DEL_AT, 32'h0, 7'd4, 1'b0, pll_pkg::STATUS_OK);
        add_row(pll_pkg::MODE_DEL_AT, 32'h0, 7'd1, 1'b0, pll_pkg::STATUS_OK);
        add_row(pll_pkg::MODE_DEL_AT, 32'h0, 7'd0, 1'b0, pll_pkg::STATUS_OK);
        add_row(pll_pkg::MODE_DEL_BACK, 32'h0, 7'd0, 1'b0, pll_pkg::STATUS_OK);
        add_row(pll_pkg::MODE_READ, 32'h0, 7'd0, 1'b0, pll_pkg::STATUS_OK);
        add_row(pll_pkg::MODE_DEL_FRONT, 32'h0, 7'd0, 1'b0, pll_pkg::STATUS_OK);
        add_row(pll_pkg::MODE_READ, 32'h0, 7'd0, 1'b1, pll_pkg::STATUS_EMPTY);
        add_row(pll_pkg::MODE_INS_BACK, 32'h5555_5555, 7'd0, 1'b0, pll_pkg::STATUS_OK);
        add_row(pll_pkg::MODE_INS_FRONT, 32'hAAAA_AAAA, 7'd64, 1'b0, pll_pkg::STATUS_OK);
        add_row(pll_pkg::MODE_READ, 32'h0, 7'd0, 1'b0, pll_pkg::STATUS_OK);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_plan[i])
            offer_item(directed_plan[i].item, directed_plan[i].fixed,
                       directed_plan[i].fixed_status);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == BACKLOG_AT)
            begin
                // receiver holds off while items keep coming back to back
                backlog_req = 1'b1;
                sender_quiet = 30;
            end
            item = random_item();
            offer_item(item, 1'b0, pll_pkg::STATUS_OK);
        end
        req_valid <= 1'b0;

        while (awaited_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && awaited_rsp.size() == 0)
            $display("positional_linked_list_engine_test: done, clean");
        else
            $display("positional_linked_list_engine_test: done, errors");
        $finish;
    end

    // Result side: check each accepted result, then choose next cycle's stall
    initial
    begin : rsp_side
        pll_pkg::rsp_t want;
        int unsigned   stall_left;
        int unsigned   hold_left;
        bit            hold_done;
        stall_left = 0;
        hold_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && rsp_valid === 1'b1 && rsp_stall === 1'b0)
            begin
                if (awaited_rsp.size() == 0)
                begin
                    error_count++;
                    $display("%0t: result with nothing expected: status %0d value %0d",
                             $time, rsp.status, rsp.item_value);
                end
                else
                begin
                    want = awaited_rsp.pop_front();
                    if (rsp.status !== want.status)
                    begin
                        error_count++;
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.status, rsp.status);
                    end
                    if (rsp.item_value !== want.item_value)
                    begin
                        error_count++;
                        $display("%0t: item_value expected %0d, got %0d",
                                 $time, want.item_value, rsp.item_value);
                    end
                    if (rsp.last_item !== want.last_item)
                    begin
                        error_count++;
                        $display("%0t: last_item expected %0b, got %0b",
                                 $time, want.last_item, rsp.last_item);
                    end
                end
            end

            if (backlog_req && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = BACKLOG_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_stall <= 1'b1;
            end
            else
            begin
                rsp_stall <= 1'b0;
                stall_left = pick_gap(receiver_quiet);
            end
        end
    end

    // Ends the run when nothing moves on either side for too long
    initial
    begin : watchdog
        int unsigned idle;
        idle = 0;
        wait (rst_n === 1'b1);
        while (idle < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid === 1'b1 && req_stall === 1'b0) ||
                (rsp_valid === 1'b1 && rsp_stall === 1'b0))
                idle = 0;
            else
                idle++;
        end
        $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("positional_linked_list_engine_test: done, errors");
        $finish;
    end

endmodule
